[hdl/ubios_pkg.sv]
package ubios_pkg;

   // ring geometry
   localparam int RING_DEPTH = 64;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;

   // request operation codes
   typedef enum logic [1:0] {
      OP_RX_BYTE  = 2'd0,
      OP_TX_READY = 2'd1,
      OP_READ     = 2'd2,
      OP_PUT      = 2'd3
   } op_type;

   // controls into one ring for the current word
   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] data;
   } ring_ctrl_type;

   // ring status seen by the request logic
   typedef struct packed {
      logic       empty;
      logic       full;
      logic       multi;
      logic [7:0] head_data;
   } ring_stat_type;

endpackage

[hdl/ubios_ring.sv]
module ubios_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  ubios_pkg::ring_ctrl_type ctrl,
   output ubios_pkg::ring_stat_type stat
);
   import ubios_pkg::*;

   logic [7:0]       mem [RING_DEPTH];
   logic [IDX_W-1:0] head_ff, head_in, tail;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] tail_sum;
   logic [7:0]       rd_ff;

   // tail position, wrapped once at most
   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(RING_DEPTH)) begin
         tail = IDX_W'(tail_sum - SUM_W'(RING_DEPTH));
      end else begin
         tail = IDX_W'(tail_sum);
      end
   end

   // next head and count
   always_comb begin
      head_in = head_ff;
      if (ctrl.pop) begin
         if (head_ff == IDX_W'(RING_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      count_in = count_ff + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
   end

   // pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // storage; read port follows the next head, with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail] <= ctrl.data;
      end
      if (ctrl.push && (tail == head_in)) begin
         rd_ff <= ctrl.data;
      end else begin
         rd_ff <= mem[head_in];
      end
   end

   // status; an empty ring shows the word being pushed so push and pop can pair
   always_comb begin
      stat.empty     = (count_ff == '0);
      stat.full      = (count_ff == CNT_W'(RING_DEPTH));
      stat.multi     = (count_ff > CNT_W'(1));
      stat.head_data = stat.empty ? ctrl.data : rd_ff;
   end

endmodule

[hdl/uart_buffered_io_server.sv]
// channel   ports                                  handshake
// request   req_operation .. req_line_busy         accepted when start && !busy
// result    rsp_deliver_valid .. rsp_dropped       valid for one cycle with rsp_strobe
//
// one request word is taken every cycle; busy stays low
// the result appears in the cycle after its request, from the result register
// back-to-back pops work because each ring's head-read register follows the next head
// synchronous reset empties all three rings; ring storage itself is not cleared
// the receiver cannot stall, so no result is ever held back
module uart_buffered_io_server (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [7:0]            req_requester_id,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_of_put,
   input  logic                  req_line_busy,
   output logic                  rsp_strobe,
   output logic                  rsp_deliver_valid,
   output logic [7:0]            rsp_deliver_id,
   output logic [7:0]            rsp_deliver_byte,
   output logic                  rsp_reader_parked,
   output logic                  rsp_line_write_valid,
   output logic [7:0]            rsp_line_write_byte,
   output logic                  rsp_tx_irq_enable,
   output logic                  rsp_dropped
);
   import ubios_pkg::*;

   ring_ctrl_type rx_ctrl, rdr_ctrl, tx_ctrl;
   ring_stat_type rx_st, rdr_st, tx_st;

   logic       accept;
   op_type     op;
   logic       attempt;
   logic       irq_after_pop;

   logic       strobe_ff;
   logic       deliver_valid_ff, deliver_valid_in;
   logic [7:0] deliver_id_ff, deliver_id_in;
   logic [7:0] deliver_byte_ff, deliver_byte_in;
   logic       parked_ff, parked_in;
   logic       write_valid_ff, write_valid_in;
   logic [7:0] write_byte_ff, write_byte_in;
   logic       irq_ff, irq_in;
   logic       dropped_ff, dropped_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign op     = op_type'(req_operation);

   // rings
   ubios_ring u_rx_ring  (.clock(clock), .reset(reset), .ctrl(rx_ctrl),  .stat(rx_st));
   ubios_ring u_rdr_ring (.clock(clock), .reset(reset), .ctrl(rdr_ctrl), .stat(rdr_st));
   ubios_ring u_tx_ring  (.clock(clock), .reset(reset), .ctrl(tx_ctrl),  .stat(tx_st));

   // request decode and ring control
   always_comb begin
      rx_ctrl          = '{push: 1'b0, pop: 1'b0, data: req_data_byte};
      rdr_ctrl         = '{push: 1'b0, pop: 1'b0, data: req_requester_id};
      tx_ctrl          = '{push: 1'b0, pop: 1'b0, data: req_data_byte};
      attempt          = 1'b0;
      irq_after_pop    = 1'b0;
      deliver_valid_in = 1'b0;
      deliver_id_in    = '0;
      deliver_byte_in  = '0;
      parked_in        = 1'b0;
      write_valid_in   = 1'b0;
      write_byte_in    = '0;
      irq_in           = 1'b0;
      dropped_in       = 1'b0;
      case (op)
         OP_RX_BYTE: begin
            if (!rdr_st.empty) begin
               deliver_valid_in = 1'b1;
               deliver_id_in    = rdr_st.head_data;
               deliver_byte_in  = req_data_byte;
               rdr_ctrl.pop     = accept;
            end else if (rx_st.full) begin
               dropped_in = 1'b1;
            end else begin
               rx_ctrl.push = accept;
            end
         end
         OP_TX_READY: begin
            attempt       = !tx_st.empty;
            irq_after_pop = tx_st.multi;
         end
         OP_READ: begin
            if (!rx_st.empty) begin
               deliver_valid_in = 1'b1;
               deliver_id_in    = req_requester_id;
               deliver_byte_in  = rx_st.head_data;
               rx_ctrl.pop      = accept;
            end else if (rdr_st.full) begin
               dropped_in = 1'b1;
            end else begin
               rdr_ctrl.push = accept;
               parked_in     = 1'b1;
            end
         end
         OP_PUT: begin
            // a put byte lands first, then the last byte tries to send
            if (tx_st.full) begin
               dropped_in    = 1'b1;
               irq_after_pop = 1'b1;
            end else begin
               tx_ctrl.push  = accept;
               irq_after_pop = !tx_st.empty;
            end
            attempt = req_last_of_put;
         end
         default: begin
            dropped_in = 1'b0;
         end
      endcase

      // transmit attempt
      if (attempt) begin
         if (req_line_busy) begin
            irq_in = 1'b1;
         end else begin
            write_valid_in = 1'b1;
            write_byte_in  = tx_st.head_data;
            tx_ctrl.pop    = accept;
            irq_in         = irq_after_pop;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
      deliver_valid_ff <= deliver_valid_in;
      deliver_id_ff    <= deliver_id_in;
      deliver_byte_ff  <= deliver_byte_in;
      parked_ff        <= parked_in;
      write_valid_ff   <= write_valid_in;
      write_byte_ff    <= write_byte_in;
      irq_ff           <= irq_in;
      dropped_ff       <= dropped_in;
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_deliver_valid    = deliver_valid_ff;
   assign rsp_deliver_id       = deliver_id_ff;
   assign rsp_deliver_byte     = deliver_byte_ff;
   assign rsp_reader_parked    = parked_ff;
   assign rsp_line_write_valid = write_valid_ff;
   assign rsp_line_write_byte  = write_byte_ff;
   assign rsp_tx_irq_enable    = irq_ff;
   assign rsp_dropped          = dropped_ff;

   // waiting readers and buffered bytes never coexist
   a_rx_or_readers : assert property (@(posedge clock) disable iff (reset)
      rx_st.empty || rdr_st.empty)
      else $error("receive ring and reader ring both hold entries");

   // a word is either delivered, parked or dropped on the read side
   a_read_outcome : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_deliver_valid && (rsp_reader_parked || rsp_dropped)))
      else $error("read-side outcomes overlap");

   // a write to the line only follows a transmit-side request
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      accept && write_valid_in |=>
         rsp_line_write_valid && ($past(op) == OP_TX_READY || $past(op) == OP_PUT))
      else $error("line write from a non-transmit request");

endmodule
